// ----- sv/serial_frame_parser_checksum_assert.svh -----
// assertion macros for the frame parser checker
`ifndef SERIAL_FRAME_PARSER_CHECKSUM_ASSERT_SVH
`define SERIAL_FRAME_PARSER_CHECKSUM_ASSERT_SVH

// property that holds at every edge outside reset
`define SFPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger at one edge implies the consequence at the next edge
`define SFPC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sfpc_pkg.sv -----
`default_nettype none
package sfpc_pkg;

    // default payload limit
    localparam int MAX_PAYLOAD_DEF = 128;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // reset values of the configuration registers
    localparam logic [7:0]  FIRST_HEADER_RST     = 8'd85;
    localparam logic [7:0]  SECOND_HEADER_RST    = 8'd170;
    localparam logic [7:0]  VERSION_BYTE_RST     = 8'd0;
    localparam logic [7:0]  START_COMMAND_RST    = 8'd10;
    localparam logic [7:0]  TRANSFER_COMMAND_RST = 8'd11;
    localparam logic [7:0]  REPORT_COMMAND_RST   = 8'd7;
    localparam logic [15:0] TIMEOUT_LIMIT_RST    = 16'd1000;

    // item opcodes and result kinds
    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [2:0] {
        REG_FIRST_HEADER,
        REG_SECOND_HEADER,
        REG_VERSION_BYTE,
        REG_START_COMMAND,
        REG_TRANSFER_COMMAND,
        REG_REPORT_COMMAND,
        REG_TIMEOUT_LIMIT
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_VER,
        PH_CMD,
        PH_LENH,
        PH_LENL,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_ERR,
        ST_TIMEOUT,
        ST_UNSUP,
        ST_LONG
    } status_t;

    typedef struct packed {
        logic [7:0]  first_header;
        logic [7:0]  second_header;
        logic [7:0]  version_byte;
        logic [7:0]  start_command;
        logic [7:0]  transfer_command;
        logic [7:0]  report_command;
        logic [15:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic [2:0] status;
        logic [7:0] command_code;
        logic [7:0] frame_length;
    } result_t;

    // declared length as reported, saturated at 255
    function automatic logic [7:0] len_sat(input logic [15:0] len);
        return (len > 16'd255) ? 8'hFF : len[7:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/sfpc_cfg.sv -----
`default_nettype none
module sfpc_cfg
    import sfpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FIRST_HEADER:     cfg_next.first_header     = pwdata[7:0];
                REG_SECOND_HEADER:    cfg_next.second_header    = pwdata[7:0];
                REG_VERSION_BYTE:     cfg_next.version_byte     = pwdata[7:0];
                REG_START_COMMAND:    cfg_next.start_command    = pwdata[7:0];
                REG_TRANSFER_COMMAND: cfg_next.transfer_command = pwdata[7:0];
                REG_REPORT_COMMAND:   cfg_next.report_command   = pwdata[7:0];
                REG_TIMEOUT_LIMIT:    cfg_next.timeout_limit    = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_header     <= FIRST_HEADER_RST;
            cfg_reg.second_header    <= SECOND_HEADER_RST;
            cfg_reg.version_byte     <= VERSION_BYTE_RST;
            cfg_reg.start_command    <= START_COMMAND_RST;
            cfg_reg.transfer_command <= TRANSFER_COMMAND_RST;
            cfg_reg.report_command   <= REPORT_COMMAND_RST;
            cfg_reg.timeout_limit    <= TIMEOUT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_FIRST_HEADER:     prdata[7:0]  = cfg_reg.first_header;
            REG_SECOND_HEADER:    prdata[7:0]  = cfg_reg.second_header;
            REG_VERSION_BYTE:     prdata[7:0]  = cfg_reg.version_byte;
            REG_START_COMMAND:    prdata[7:0]  = cfg_reg.start_command;
            REG_TRANSFER_COMMAND: prdata[7:0]  = cfg_reg.transfer_command;
            REG_REPORT_COMMAND:   prdata[7:0]  = cfg_reg.report_command;
            REG_TIMEOUT_LIMIT:    prdata[15:0] = cfg_reg.timeout_limit;
            default:              prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/sfpc_in_reg.sv -----
`default_nettype none
module sfpc_in_reg
    import sfpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire item_t item,
    input  wire logic  take,
    output logic       fire,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // held item moves on when the result side can take its outcome
    assign fire       = valid_reg && take;
    assign item_ready = !valid_reg || take;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule
`default_nettype wire

// ----- sv/sfpc_parse.sv -----
`default_nettype none
module sfpc_parse
    import sfpc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  fire,
    input  wire item_t held_item,
    output logic       has_res,
    output result_t    res
);

    localparam int SEEN_W = $clog2(MAX_PAYLOAD + 1);

    phase_t            phase_reg, phase_next;
    logic [7:0]        sum_reg, sum_next;
    logic [15:0]       len_reg, len_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [15:0]       idle_reg, idle_next;

    logic [7:0]        b;
    logic [15:0]       idle_sat;
    logic [SEEN_W-1:0] seen_inc;
    logic [15:0]       seen_wide;
    logic              end_frame;
    status_t           end_status;
    logic              cmd_known;

    assign b         = held_item.rx_byte;
    assign idle_sat  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign seen_inc  = seen_reg + SEEN_W'(1);
    assign seen_wide = 16'(seen_reg);
    assign cmd_known = (cmd_reg == cfg.start_command) || (cmd_reg == cfg.transfer_command)
                    || (cmd_reg == cfg.report_command);

    // next frame state and the result of the held item
    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        cmd_next   = cmd_reg;
        idle_next  = idle_reg;
        end_frame  = 1'b0;
        end_status = ST_OK;
        has_res    = 1'b0;
        res        = '0;

        if (held_item.opcode == OP_TICK)
        begin
            idle_next = idle_sat;
            if (idle_sat >= cfg.timeout_limit)
            begin
                idle_next  = '0;
                end_frame  = 1'b1;
                end_status = ST_TIMEOUT;
            end
        end
        else
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_HEAD1:
                begin
                    if (b != cfg.first_header)
                    begin
                        end_frame  = 1'b1;
                        end_status = ST_ERR;
                    end
                    else
                    begin
                        sum_next   = b;
                        phase_next = PH_HEAD2;
                    end
                end
                PH_HEAD2:
                begin
                    if (b != cfg.second_header)
                    begin
                        end_frame  = 1'b1;
                        end_status = ST_ERR;
                    end
                    else
                    begin
                        sum_next   = sum_reg + b;
                        phase_next = PH_VER;
                    end
                end
                PH_VER:
                begin
                    if (b != cfg.version_byte)
                    begin
                        end_frame  = 1'b1;
                        end_status = ST_ERR;
                    end
                    else
                    begin
                        sum_next   = sum_reg + b;
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    cmd_next   = b;
                    sum_next   = sum_reg + b;
                    phase_next = PH_LENH;
                end
                PH_LENH:
                begin
                    len_next   = {b, 8'h00};
                    sum_next   = sum_reg + b;
                    phase_next = PH_LENL;
                end
                PH_LENL:
                begin
                    len_next = len_reg + 16'(b);
                    sum_next = sum_reg + b;
                    seen_next = '0;
                    if (len_next > 16'(MAX_PAYLOAD))
                    begin
                        end_frame  = 1'b1;
                        end_status = ST_LONG;
                    end
                    else if (len_next == 16'd0)
                    begin
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    has_res               = 1'b1;
                    res.kind              = KIND_PAYLOAD;
                    res.payload_byte      = b;
                    res.payload_index     = seen_wide[6:0];
                    res.status            = ST_OK;
                    res.command_code      = cmd_reg;
                    res.frame_length      = len_sat(len_reg);
                    sum_next              = sum_reg + b;
                    seen_next             = seen_inc;
                    if (16'(seen_inc) >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    end_frame = 1'b1;
                    if (b != sum_reg)
                    begin
                        end_status = ST_ERR;
                    end
                    else if (cmd_known)
                    begin
                        end_status = ST_OK;
                    end
                    else
                    begin
                        end_status = ST_UNSUP;
                    end
                end
            endcase
        end

        // frame end report, then back to waiting for a header
        if (end_frame)
        begin
            has_res          = 1'b1;
            res.kind         = KIND_END;
            res.status       = end_status;
            res.command_code = cmd_reg;
            res.frame_length = len_sat(len_next);
            phase_next       = PH_HEAD1;
            sum_next         = '0;
            len_next         = '0;
            seen_next        = '0;
            cmd_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD1;
            sum_reg   <= '0;
            len_reg   <= '0;
            seen_reg  <= '0;
            cmd_reg   <= '0;
            idle_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            cmd_reg   <= cmd_next;
            idle_reg  <= idle_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/sfpc_out_reg.sv -----
`default_nettype none
module sfpc_out_reg
    import sfpc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire logic    has_res,
    input  wire result_t res,
    output logic         take,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // room for a new result when empty or being drained this cycle
    assign take         = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = has_res;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_res)
        begin
            result_reg <= res;
        end
    end

endmodule
`default_nettype wire

// ----- sv/serial_frame_parser_checksum.sv -----
`default_nettype none
// Frame parser for a serial byte stream with an additive checksum.
// item channel (valid/ready): opcode 0 carries a received byte, opcode 1 a time tick.
// result channel (valid/ready): a payload byte with its index, or a frame end
// status with the command byte and the declared length (saturated at 255).
// A transaction on the item channel gives zero or one result transaction.
// Each result is registered: the item is held in the input register, then the
// parser state update loads the result register once the result side has room.
// Throughput: one item per cycle while the result side has room; the parser state
// moves on per item, so any item, byte or tick, can follow the previous one directly.
// A held result does not block the input register: while the result waits, one
// more item is taken; if the receiver keeps stalling, item_ready drops once
// that item is waiting too, and no result is dropped.
// Configuration registers sit on the APB port, four bytes apart; the user writes them
// only while no item is in flight, and the block does not enforce it.
// Reset (rst_n low, asynchronous) empties both registers, returns the parser to
// waiting for the first header byte, clears the idle tick count and loads the
// configuration registers with their default values.
module serial_frame_parser_checksum
    import sfpc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire item_t             item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output result_t                result
);

    cfg_t    cfg;
    item_t   held_item;
    logic    fire;
    logic    take;
    logic    has_res;
    result_t res;

    // configuration registers
    sfpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    sfpc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (take),
        .fire       (fire),
        .held_item  (held_item)
    );

    // frame state machine
    sfpc_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .held_item (held_item),
        .has_res   (has_res),
        .res       (res)
    );

    // result register
    sfpc_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .has_res      (has_res),
        .res          (res),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- sv/sfpc_checker.sv -----
`default_nettype none
`include "serial_frame_parser_checksum_assert.svh"
module sfpc_checker
    import sfpc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    logic res_stall;
    logic item_fire;
    logic fields_ok;
    logic index_ok;

    assign res_stall = result_valid && !result_ready;
    assign item_fire = item_valid && item_ready;

    // unused fields of each result kind read as zero
    assign fields_ok = !result_valid
                    || (result.kind == KIND_PAYLOAD ? result.status == 3'(ST_OK)
                        : (result.payload_byte == 8'd0 && result.payload_index == 7'd0));

    // a payload byte lies inside its declared length
    assign index_ok = !result_valid || result.kind != KIND_PAYLOAD
                   || 8'(result.payload_index) < result.frame_length;

    // stalled result holds
    `SFPC_ASSERT_NEXT(a_result_hold, res_stall, result_valid && $stable(result), "result moved")

    `SFPC_ASSERT_ALWAYS(a_kind_fields, fields_ok, "unused result fields not zero")

    `SFPC_ASSERT_ALWAYS(a_index_in_frame, index_ok, "payload index beyond frame length")

    // a new result follows an earlier item transaction
    `SFPC_ASSERT_ALWAYS(a_res_source, !$rose(result_valid) || $past(item_fire, 2), "stray result")

endmodule

bind serial_frame_parser_checksum sfpc_checker u_sfpc_checker (.*);
`default_nettype wire
